// File: rtl/fourier_terrain_altitude_unit_defines.svh
// Assertion macros shared by the terrain altitude RTL.
`ifndef FOURIER_TERRAIN_ALTITUDE_UNIT_DEFINES_SVH
`define FOURIER_TERRAIN_ALTITUDE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FTALT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terrain altitude assertion failed");
`define FTALT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terrain altitude assertion failed");
`else
`define FTALT_ASSERT_IMP(lbl, ante, cons)
`define FTALT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/ftalt_pkg.sv
// Types, constants and the sine table of the terrain altitude unit.
package ftalt_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int IDX_W        = $clog2(SINE_ENTRIES);
    localparam int ANGLES       = 6;
    localparam int SUM_W        = 36;
    localparam int OFF_W        = SUM_W - 8;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] SINE_SCALE  = 64'h000000007FFFFFFF;
    localparam logic [63:0] HALF_PI_DIV = HALF_PI_Q61 / SINE_ENTRIES;
    localparam logic [63:0] HALF_PI_REM = HALF_PI_Q61 % SINE_ENTRIES;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PAD_EXTENT = 2'd0,
        REG_PAD_HEIGHT = 2'd1,
        REG_MID_HEIGHT = 2'd2,
        REG_SEA_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        [30:0] pad_extent;
        logic signed [31:0] pad_height;
        logic signed [31:0] mid_height;
        logic signed [31:0] sea_height;
    } cfg_t;

    typedef logic [ANGLES-1:0][31:0] angle_vec_t;
    typedef logic signed [31:0] sine_table_t [SINE_ENTRIES];

    function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // Long division, shift and subtract one quotient bit at a time.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] q61_sin(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] den;
        t2   = q61_mul(t, t);
        term = t;
        acc  = t;
        for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                den  = 64'((2 * n) * (2 * n + 1));
                term = udiv64(q61_mul(term, t2), den);
                if (n % 2 == 1) begin
                    acc = acc - term;
                end
                else begin
                    acc = acc + term;
                end
            end
        end
        return acc;
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t  tbl;
        logic [63:0]  u;
        logic [63:0]  t;
        logic [63:0]  theta;
        logic [63:0]  s;
        logic [63:0]  mag;
        logic [127:0] p;
        logic         neg;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            u   = 64'(4 * i);
            neg = 1'b0;
            if (u <= 64'(SINE_ENTRIES)) begin
                t = u;
            end
            else if (u <= 64'(2 * SINE_ENTRIES)) begin
                t = 64'(2 * SINE_ENTRIES) - u;
            end
            else if (u <= 64'(3 * SINE_ENTRIES)) begin
                t   = u - 64'(2 * SINE_ENTRIES);
                neg = 1'b1;
            end
            else begin
                t   = 64'(4 * SINE_ENTRIES) - u;
                neg = 1'b1;
            end
            theta = HALF_PI_DIV * t + (HALF_PI_REM * t) / SINE_ENTRIES;
            s     = q61_sin(theta);
            p     = {64'd0, s} * {64'd0, SINE_SCALE} + (128'd1 << 60);
            mag   = p[124:61];
            if (mag > SINE_SCALE) begin
                mag = SINE_SCALE;
            end
            tbl[i] = neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    function automatic logic [IDX_W-1:0] sine_index(input logic [31:0] angle);
        logic [63:0] p;
        p = {32'd0, angle} * 64'(SINE_ENTRIES);
        return p[32 +: IDX_W];
    endfunction

endpackage

// File: rtl/fourier_terrain_altitude_unit.sv
// Terrain altitude unit: top level with the four-stage sine pipeline.
//
// Input channel: x_pos and z_pos (signed 8.24) with in_valid and in_stall.
// Output channel: altitude (signed 8.24) with out_valid and out_stall.
// An item moves at a rising edge where valid is high and stall is low.
// Configuration: cfg_we writes cfg_data to register cfg_index at a rising
// edge (0 pad_extent, 1 pad_height, 2 mid_height, 3 sea_height); write only
// while no item is in flight.
// Path: an accepted item passes four registers (angles, sine table read,
// weighted sum, clamp) before its result is offered.
// Throughput: one item per cycle while the receiver does not stall; the three
// dual-port sine tables serve all six terms of an item in the same cycle.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling; in_stall rises once all four are full.
// Reset clears the stage valid bits and loads the register defaults; the
// sine table is a constant and needs no fill.
`include "fourier_terrain_altitude_unit_defines.svh"

module fourier_terrain_altitude_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ftalt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [31:0]                 x_pos,
    input  logic signed [31:0]                 z_pos,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 altitude
);

    ftalt_pkg::cfg_t       cfg;
    ftalt_pkg::angle_vec_t angles;
    ftalt_pkg::angle_vec_t angle_reg;
    logic [ftalt_pkg::IDX_W-1:0] idx [ftalt_pkg::ANGLES];
    logic signed [31:0]    sine_val [ftalt_pkg::ANGLES];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    logic pad_hit;
    logic pad1_reg, pad2_reg, pad3_reg;
    logic signed [ftalt_pkg::SUM_W-1:0] sum_next;
    logic signed [ftalt_pkg::OFF_W-1:0] off_reg;
    logic signed [31:0] alt_raw;
    logic signed [31:0] alt_next;
    logic signed [31:0] alt_reg;

    ftalt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftalt_angle_gen u_angle (
        .x_pos  (x_pos),
        .z_pos  (z_pos),
        .angles (angles)
    );

    assign ready4   = !v4_reg || !out_stall;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    assign pad_hit = !x_pos[31] && !z_pos[31] &&
                     (x_pos[30:0] < cfg.pad_extent) && (z_pos[30:0] < cfg.pad_extent);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < ftalt_pkg::ANGLES; k++)
        begin
            idx[k] = ftalt_pkg::sine_index(angle_reg[k]);
        end
    end

    for (genvar g = 0; g < ftalt_pkg::ANGLES / 2; g++)
    begin : g_rom
        ftalt_sine_rom u_rom (
            .clk    (clk),
            .en     (ready2),
            .addr_a (idx[2*g]),
            .addr_b (idx[2*g+1]),
            .data_a (sine_val[2*g]),
            .data_b (sine_val[2*g+1])
        );
    end

    always_comb
    begin
        sum_next = ((ftalt_pkg::SUM_W'(sine_val[0]) + ftalt_pkg::SUM_W'(sine_val[1]) +
                     ftalt_pkg::SUM_W'(sine_val[2]) + ftalt_pkg::SUM_W'(sine_val[3])) <<< 1) +
                   ftalt_pkg::SUM_W'(sine_val[4]) + ftalt_pkg::SUM_W'(sine_val[5]);
        alt_raw  = cfg.mid_height - 32'(off_reg);
        if (pad3_reg)
        begin
            alt_next = cfg.pad_height;
        end
        else if (alt_raw > cfg.sea_height)
        begin
            alt_next = cfg.sea_height;
        end
        else
        begin
            alt_next = alt_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            angle_reg <= angles;
            pad1_reg  <= pad_hit;
        end
        if (ready2)
        begin
            pad2_reg <= pad1_reg;
        end
        if (ready3)
        begin
            off_reg  <= sum_next[ftalt_pkg::SUM_W-1:8];
            pad3_reg <= pad2_reg;
        end
        if (ready4)
        begin
            alt_reg <= alt_next;
        end
    end

    assign out_valid = v4_reg;
    assign altitude  = alt_reg;

    `FTALT_ASSERT_NXT(a_accept_fills_stage, in_valid && !in_stall, v1_reg)
    `FTALT_ASSERT_IMP(a_stall_only_when_full, in_stall, v2_reg && v3_reg && out_valid && out_stall)
    `FTALT_ASSERT_NXT(a_pad_result, v3_reg && pad3_reg && ready4, altitude == $past(cfg.pad_height))

endmodule

// File: rtl/ftalt_cfg_regs.sv
// Configuration registers of the terrain altitude unit.
module ftalt_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ftalt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                        cfg_data,
    output ftalt_pkg::cfg_t                    cfg
);

    ftalt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pad_extent <= 31'h08000000;
            cfg_reg.pad_height <= 32'sh03000000;
            cfg_reg.mid_height <= 32'sh05000000;
            cfg_reg.sea_height <= 32'sh05500000;
        end
        else if (cfg_we)
        begin
            unique case (ftalt_pkg::cfg_index_t'(cfg_index))
                ftalt_pkg::REG_PAD_EXTENT: cfg_reg.pad_extent <= cfg_data[30:0];
                ftalt_pkg::REG_PAD_HEIGHT: cfg_reg.pad_height <= $signed(cfg_data);
                ftalt_pkg::REG_MID_HEIGHT: cfg_reg.mid_height <= $signed(cfg_data);
                ftalt_pkg::REG_SEA_HEIGHT: cfg_reg.sea_height <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ftalt_angle_gen.sv
// Six wrapping angle combinations of the ground coordinates.
module ftalt_angle_gen (
    input  logic [31:0]           x_pos,
    input  logic [31:0]           z_pos,
    output ftalt_pkg::angle_vec_t angles
);

    logic [31:0] x2, x3, x4, x5, x10;
    logic [31:0] z2, z3, z7, z11;

    always_comb
    begin
        x2  = x_pos << 1;
        x4  = x_pos << 2;
        x3  = x2 + x_pos;
        x5  = x4 + x_pos;
        x10 = x5 << 1;
        z2  = z_pos << 1;
        z3  = z2 + z_pos;
        z7  = (z_pos << 3) - z_pos;
        z11 = (z_pos << 3) + z3;
        angles[0] = x_pos - z2;
        angles[1] = x4 + z3;
        angles[2] = z3 - x5;
        angles[3] = x3 + z3;
        angles[4] = x5 + z11;
        angles[5] = x10 + z7;
    end

endmodule

// File: rtl/ftalt_sine_rom.sv
// Dual-port sine table with registered read data.
module ftalt_sine_rom (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ftalt_pkg::IDX_W-1:0] addr_a,
    input  logic [ftalt_pkg::IDX_W-1:0] addr_b,
    output logic signed [31:0]          data_a,
    output logic signed [31:0]          data_b
);

    logic signed [31:0] data_a_reg;
    logic signed [31:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= ftalt_pkg::SINE_TABLE[addr_a];
            data_b_reg <= ftalt_pkg::SINE_TABLE[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule
